### design/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, widths and helpers for the subtour cut separation block.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int unsigned SUM_W   = 22;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  localparam logic TYPE_CUT     = 1'b0;
  localparam logic TYPE_SUMMARY = 1'b1;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_PICK_THR   = 2'd1;
  localparam logic [1:0] REG_CUT_THR    = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [10:0] edge_index;
    logic [15:0] edge_weight;
  } stc_in_t;

  typedef struct packed {
    logic             item_type;
    logic [5:0]       root_node;
    logic [63:0]      member_mask;
    logic [SUM_W-1:0] boundary_weight;
    logic [5:0]       cut_count;
    logic             last;
  } stc_out_t;

  // state held by one node cell
  typedef struct packed {
    logic [SUM_W-1:0] conn;
    logic             unas;
    logic             inset;
  } stc_node_t;

  // broadcast control to the row of cells
  typedef struct packed {
    logic shift;
    logic clr_all;
    logic clr_set;
  } stc_cell_ctl_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

### design/stc_cell.sv
// ----------------------------------------------------------------------------
// stc_cell
// One node cell of the ring: holds a node's connection sum and flags.
// ----------------------------------------------------------------------------
module stc_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stc_pkg::stc_cell_ctl_t ctl,
  input  stc_pkg::stc_node_t    d,
  output stc_pkg::stc_node_t    q
);
  import stc_pkg::*;

  stc_node_t node_r;

  // sum is always rewritten by the root pass before use, so it has no reset
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      node_r.conn <= d.conn;
    end
    if (!rst_n) begin
      node_r.unas  <= 1'b1;
      node_r.inset <= 1'b0;
    end else if (ctl.clr_all) begin
      node_r.unas  <= 1'b1;
      node_r.inset <= 1'b0;
    end else if (ctl.clr_set) begin
      node_r.inset <= 1'b0;
    end else if (ctl.shift) begin
      node_r.unas  <= d.unas;
      node_r.inset <= d.inset;
    end
  end

  assign q = node_r;

endmodule

### design/subtour_cut_separation.sv
// ----------------------------------------------------------------------------
// subtour_cut_separation
// Greedy subtour cut separation over a ring of node cells.
// ----------------------------------------------------------------------------
// Load items (kind 0) write one Q1.15 edge weight into the triangular weight
// store and are taken one per cycle while the block is idle. A run item
// (kind 1) stalls the input until its summary item has been loaded into the
// output register. Node state lives in a ring of MAX_NODES cells that rotates
// once per pass; the head node is updated with one weight read from the store
// each cycle of a pass, and each pass is followed by a decision step.
// Weights of unwritten edges are undefined; every edge among the nodes in
// use must be loaded before a run.
module subtour_cut_separation #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  stc_pkg::stc_in_t   in_data,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output stc_pkg::stc_out_t  out_data,
  // configuration
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import stc_pkg::*;

  localparam int unsigned DEPTH = MAX_NODES * (MAX_NODES - 1) / 2 + 1;
  localparam int unsigned MW    = $clog2(DEPTH);
  localparam int unsigned AW    = $clog2(MAX_NODES);
  localparam int unsigned CW    = $clog2(MAX_NODES + 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_START   = 3'd1;
  localparam logic [2:0] ST_ROOT    = 3'd2;
  localparam logic [2:0] ST_PASS    = 3'd3;
  localparam logic [2:0] ST_DECIDE  = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;
  localparam logic [2:0] ST_SUMMARY = 3'd6;

  // ---------------- configuration registers ----------------
  logic [6:0]  node_count_r;
  logic [15:0] pick_thr_r;
  logic [21:0] cut_thr_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd64;
      pick_thr_r   <= 16'd3277;
      cut_thr_r    <= 22'd65535;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_NODE_COUNT: node_count_r <= cfg_pwdata[6:0];
        REG_PICK_THR:   pick_thr_r   <= cfg_pwdata[15:0];
        REG_CUT_THR:    cut_thr_r    <= cfg_pwdata[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_NODE_COUNT: cfg_prdata = {25'd0, node_count_r};
      REG_PICK_THR:   cfg_prdata = {16'd0, pick_thr_r};
      REG_CUT_THR:    cfg_prdata = {10'd0, cut_thr_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // nodes in use, clipped to the ring length
  logic [6:0] n_eff;
  assign n_eff = (node_count_r > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count_r;

  // ---------------- control state ----------------
  logic [2:0]       state_r, state_nxt;
  logic [AW:0]      root_r, root_nxt;
  logic [AW-1:0]    tgt_r, tgt_nxt;
  logic             init_r, init_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [5:0]       cuts_r, cuts_nxt;

  // pass statistics
  logic [SUM_W-1:0] bnd_r, bnd_nxt;
  logic             outside_r, outside_nxt;
  logic             found_r, found_nxt;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic [AW-1:0]    bi_r, bi_nxt;
  logic [MAX_NODES-1:0] mask_r, mask_nxt;

  // output register
  logic     out_valid_r;
  stc_out_t out_data_r;
  logic     out_free, out_load;
  stc_out_t out_load_data;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_stall  = (state_r != ST_IDLE);

  // ---------------- weight store ----------------
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data_r;
  logic          wr_en;
  logic [AW-1:0] rd_node;
  logic [AW-1:0] ex, ey;
  logic [10:0]   rd_idx;
  logic [21:0]   tri_prod;

  assign wr_en   = in_valid && !in_stall && (in_data.kind == KIND_LOAD) &&
                   (in_data.edge_index < 11'(DEPTH));
  assign rd_node = cnt_r[AW-1:0];
  assign ex      = (rd_node > tgt_r) ? rd_node : tgt_r;
  assign ey      = (rd_node > tgt_r) ? tgt_r : rd_node;
  assign tri_prod = 22'({11'(ex)} * {11'(ex - 1'b1)});
  assign rd_idx  = 11'(tri_prod >> 1) + 11'(ey) + 11'd1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_data.edge_index[MW-1:0]] <= in_data.edge_weight;
    end
    rd_data_r <= mem[rd_idx[MW-1:0]];
  end

  // ---------------- ring of node cells ----------------
  stc_cell_ctl_t ctl;
  stc_node_t     cell_q [MAX_NODES];
  stc_node_t     head_new;

  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    stc_node_t d_in;
    if (g == MAX_NODES - 1) begin : g_tail
      assign d_in = head_new;
    end else begin : g_mid
      assign d_in = cell_q[g+1];
    end
    stc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .d     (d_in),
      .q     (cell_q[g])
    );
  end

  // head processing: node k sits in cell 0 while cnt = k+1
  logic [AW-1:0]    k;
  logic             k_live, is_tgt;
  logic [SUM_W-1:0] w_ext;
  logic             proc;

  assign proc   = (state_r == ST_PASS) && (cnt_r != '0);
  assign k      = AW'(cnt_r - 1'b1);
  assign k_live = (7'(k) < n_eff);
  assign is_tgt = (k == tgt_r);
  assign w_ext  = (is_tgt || !k_live) ? '0 : SUM_W'(rd_data_r);

  always_comb begin
    head_new.unas  = cell_q[0].unas & ~is_tgt;
    head_new.inset = cell_q[0].inset | is_tgt;
    head_new.conn  = init_r ? w_ext : sat_add(cell_q[0].conn, w_ext);
  end

  // ---------------- sequencer ----------------
  logic root_unas;
  assign root_unas = cell_q[root_r[AW-1:0]].unas;

  always_comb begin
    state_nxt   = state_r;
    root_nxt    = root_r;
    tgt_nxt     = tgt_r;
    init_nxt    = init_r;
    cnt_nxt     = cnt_r;
    cuts_nxt    = cuts_r;
    bnd_nxt     = bnd_r;
    outside_nxt = outside_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    bi_nxt      = bi_r;
    mask_nxt    = mask_r;
    ctl         = '0;
    out_load    = 1'b0;
    out_load_data = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_data.kind == KIND_RUN) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        ctl.clr_all = 1'b1;
        root_nxt    = '0;
        cuts_nxt    = '0;
        state_nxt   = ST_ROOT;
      end
      ST_ROOT: begin
        if (7'(root_r) >= n_eff) begin
          state_nxt = ST_SUMMARY;
        end else if (root_unas) begin
          ctl.clr_set = 1'b1;
          tgt_nxt     = root_r[AW-1:0];
          init_nxt    = 1'b1;
          cnt_nxt     = '0;
          bnd_nxt     = '0;
          outside_nxt = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = ST_PASS;
        end else begin
          root_nxt = root_r + 1'b1;
        end
      end
      ST_PASS: begin
        cnt_nxt = cnt_r + 1'b1;
        if (proc) begin
          ctl.shift = 1'b1;
          mask_nxt  = {head_new.inset & k_live, mask_r[MAX_NODES-1:1]};
          if (k_live) begin
            if (!head_new.inset) begin
              outside_nxt = 1'b1;
              bnd_nxt     = sat_add(bnd_r, head_new.conn);
            end
            if (head_new.unas && (!found_r || head_new.conn > best_r)) begin
              found_nxt = 1'b1;
              best_nxt  = head_new.conn;
              bi_nxt    = k;
            end
          end
          if (cnt_r == CW'(MAX_NODES)) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (!init_r && !outside_r) begin
          root_nxt  = root_r + 1'b1;
          state_nxt = ST_ROOT;
        end else if (!init_r && bnd_r < cut_thr_r) begin
          state_nxt = ST_EMIT;
        end else if (!found_r || best_r < SUM_W'(pick_thr_r)) begin
          root_nxt  = root_r + 1'b1;
          state_nxt = ST_ROOT;
        end else begin
          tgt_nxt     = bi_r;
          init_nxt    = 1'b0;
          cnt_nxt     = '0;
          bnd_nxt     = '0;
          outside_nxt = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = ST_PASS;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load                      = 1'b1;
          out_load_data.item_type       = TYPE_CUT;
          out_load_data.root_node       = 6'(root_r);
          out_load_data.member_mask     = 64'(mask_r);
          out_load_data.boundary_weight = bnd_r;
          out_load_data.cut_count       = cuts_r + 6'd1;
          out_load_data.last            = 1'b0;
          cuts_nxt  = cuts_r + 6'd1;
          root_nxt  = root_r + 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_SUMMARY: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_load_data.item_type = TYPE_SUMMARY;
          out_load_data.cut_count = cuts_r;
          out_load_data.last      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    root_r    <= root_nxt;
    tgt_r     <= tgt_nxt;
    init_r    <= init_nxt;
    cnt_r     <= cnt_nxt;
    cuts_r    <= cuts_nxt;
    bnd_r     <= bnd_nxt;
    outside_r <= outside_nxt;
    found_r   <= found_nxt;
    best_r    <= best_nxt;
    bi_r      <= bi_nxt;
    mask_r    <= mask_nxt;
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

endmodule
